### hdl/abre_pkg.sv
package abre_pkg;
  localparam int NumSym = 256;
  localparam int SymW = 8;
  localparam int CntW = 18;
  localparam int GrpN = 8;
  localparam int GrpW = 3;
  localparam int IncW = 11;
  localparam logic [IncW-1:0] IncReset = 11'd64;
  localparam logic [31:0] SettleLimit = 32'h0100_0000;
  localparam logic [31:0] RangeFloor = 32'h0001_0000;
  localparam logic [CntW-1:0] TotReset = 18'd256;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WALK, S_DIV, S_MUL1, S_MUL2, S_NORM, S_UPD,
    S_RESC, S_FLUSH
  } state_t;
endpackage

### hdl/abre_ram.sv
module abre_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hdl/abre_div.sv
// Restoring divider, one quotient bit per cycle.
module abre_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [31:0]              dividend,
  input  logic [abre_pkg::CntW-1:0] divisor,
  output logic                     done,
  output logic [31:0]              quotient
);
  logic [5:0] cnt;
  logic busy;
  logic [abre_pkg::CntW:0] rem;
  logic [abre_pkg::CntW:0] trial;
  logic [abre_pkg::CntW-1:0] dsr;

  assign trial = {rem[abre_pkg::CntW-1:0], quotient[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dsr}) begin
        rem <= trial - {1'b0, dsr};
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem <= trial;
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end
endmodule

### hdl/adaptive_byte_range_encoder.sv
// Each input beat passes through a count walk, a divide and the multiply states
// S_MUL1 and S_MUL2 before its code bytes go out.
// The encoder takes one item at a time; a rescale adds a pass over the count RAM,
// end of block a flush and a clear. Reset (rst, synchronous, active high) starts the
// same clear of the count RAM, during which no item is taken.
module adaptive_byte_range_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] symbol,
  input  logic       end_of_block,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] code_byte,
  output logic       last_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [10:0] cfg_data
);
  localparam int CW = abre_pkg::CntW;

  abre_pkg::state_t state, state_next;

  logic [abre_pkg::IncW-1:0] inc;
  logic [31:0] low, rng, step;
  logic [CW-1:0] total, cum, cnt_sym;
  logic [CW-1:0] grp [abre_pkg::GrpN];
  logic [7:0] sym;
  logic eob;
  logic [8:0] idx;      // walk / sweep counter, bit 8 marks end
  logic rd_pend;        // a RAM read issued last cycle
  logic [7:0] rd_addr_q;
  logic [2:0] nbytes;   // normalization bytes emitted
  logic [2:0] fbytes;   // flush bytes emitted
  logic [CW-1:0] rsum;

  // count RAM
  logic ram_we;
  logic [7:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_wdata, ram_rdata;

  abre_ram #(.Width(CW), .Depth(abre_pkg::NumSym)) u_cnt (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic div_start, div_done;
  logic [31:0] div_q;
  abre_div u_div (
    .clk, .rst, .start(div_start), .dividend(rng), .divisor(total),
    .done(div_done), .quotient(div_q)
  );

  assign cfg_ready = 1'b1;
  assign in_stall = (state != abre_pkg::S_IDLE) || out_valid;

  // normalization decision on current low/rng
  logic [31:0] lr;
  logic settled;
  assign lr = low + rng;
  assign settled = (low ^ lr) < abre_pkg::SettleLimit;
  logic emit_norm;
  assign emit_norm = (nbytes < 3'd4) && (settled || rng < abre_pkg::RangeFloor);

  // low/rng after the byte about to go out; a further byte follows only if the
  // shifted pair still asks for one and the per-symbol cap is not reached
  logic [31:0] rng_emit, low_nx, rng_nx, lr_nx;
  logic more_norm;
  assign rng_emit = settled ? rng : {16'd0, 16'd0 - low[15:0]};
  assign low_nx = low << 8;
  assign rng_nx = rng_emit << 8;
  assign lr_nx = low_nx + rng_nx;
  assign more_norm = (nbytes < 3'd3) &&
                     (((low_nx ^ lr_nx) < abre_pkg::SettleLimit) ||
                      (rng_nx < abre_pkg::RangeFloor));

  logic [CW:0] tot_inc;
  assign tot_inc = {1'b0, total} + {8'd0, inc};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      abre_pkg::S_CLEAR: if (idx == 9'd255) state_next = abre_pkg::S_IDLE;
      abre_pkg::S_IDLE:  if (in_valid && !in_stall) state_next = abre_pkg::S_WALK;
      abre_pkg::S_WALK:  if (idx[8] && !rd_pend) state_next = abre_pkg::S_DIV;
      abre_pkg::S_DIV:   if (div_done) state_next = abre_pkg::S_MUL1;
      abre_pkg::S_MUL1:  state_next = abre_pkg::S_MUL2;
      abre_pkg::S_MUL2:  state_next = abre_pkg::S_NORM;
      abre_pkg::S_NORM:  if (!out_valid && !emit_norm) state_next = abre_pkg::S_UPD;
      abre_pkg::S_UPD: begin
        if (eob) state_next = abre_pkg::S_FLUSH;
        else if (tot_inc > {1'b0, abre_pkg::RangeFloor[CW-1:0]})
          state_next = abre_pkg::S_RESC;
        else state_next = abre_pkg::S_IDLE;
      end
      abre_pkg::S_RESC:  if (idx[8] && !rd_pend) state_next = abre_pkg::S_IDLE;
      abre_pkg::S_FLUSH: if (!out_valid && fbytes == 3'd4) state_next = abre_pkg::S_CLEAR;
      default: state_next = abre_pkg::S_CLEAR;
    endcase
  end

  // RAM and divider controls
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = rd_addr_q;
    ram_wdata = '0;
    ram_raddr = idx[7:0];
    div_start = 1'b0;
    unique case (state)
      abre_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = idx[7:0];
      end
      abre_pkg::S_WALK: if (idx[8]) ram_raddr = sym;
      abre_pkg::S_UPD: begin
        ram_we = 1'b1;
        ram_waddr = sym;
        ram_wdata = cnt_sym + CW'(inc);
      end
      abre_pkg::S_RESC: begin
        ram_we = rd_pend;
        ram_wdata = ram_rdata >> 1;
      end
      abre_pkg::S_DIV: div_start = 1'b0;
      default: ;
    endcase
    if (state == abre_pkg::S_WALK && state_next == abre_pkg::S_DIV) div_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abre_pkg::S_CLEAR;
      inc <= abre_pkg::IncReset;
      out_valid <= 1'b0;
      idx <= '0;
      rd_pend <= 1'b0;
      low <= '0;
      rng <= '1;
      total <= abre_pkg::TotReset;
      for (int g = 0; g < abre_pkg::GrpN; g++) grp[g] <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) inc <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      rd_pend <= 1'b0;
      rd_addr_q <= ram_raddr;
      unique case (state)
        abre_pkg::S_CLEAR: begin
          low <= '0;
          rng <= '1;
          total <= abre_pkg::TotReset;
          for (int g = 0; g < abre_pkg::GrpN; g++) grp[g] <= '0;
          if (idx == 9'd255) idx <= '0;
          else idx <= idx + 9'd1;
        end
        abre_pkg::S_IDLE: if (in_valid && !in_stall) begin
          sym <= symbol;
          eob <= end_of_block;
          cum <= CW'(symbol) + grp[symbol[7:5]];
          idx <= {1'b0, symbol[7:5], 5'd0};
          nbytes <= '0;
          fbytes <= '0;
        end
        abre_pkg::S_WALK: begin
          // read counts below sym in its group, then the symbol itself
          if (rd_pend) begin
            if (idx[8]) cnt_sym <= ram_rdata;
            else cum <= cum + ram_rdata;
          end
          if (!idx[8]) begin
            if (idx[7:0] == sym) begin
              idx <= 9'h100;
              rd_pend <= 1'b1;
            end else begin
              idx <= idx + 9'd1;
              rd_pend <= 1'b1;
            end
          end else if (rd_pend && rd_addr_q != sym) begin
            rd_pend <= 1'b1;
          end
        end
        abre_pkg::S_DIV: if (div_done) step <= div_q;
        abre_pkg::S_MUL1: low <= low + 32'(cum) * step;
        abre_pkg::S_MUL2: rng <= step * (32'(cnt_sym) + 32'd1);
        abre_pkg::S_NORM: if (!out_valid && emit_norm) begin
          // an unsettled top byte forces rng to (-low) & 0xFFFF before the shift;
          // flag the beat as last when nothing follows it, flush included
          out_valid <= 1'b1;
          code_byte <= low[31:24];
          last_byte <= !eob && !more_norm;
          rng <= rng_nx;
          low <= low_nx;
          nbytes <= nbytes + 3'd1;
        end
        abre_pkg::S_UPD: begin
          for (int g = 0; g < abre_pkg::GrpN; g++)
            if (3'(g) > sym[7:5]) grp[g] <= grp[g] + CW'(inc);
          total <= tot_inc[CW-1:0];
          idx <= '0;
          rsum <= '0;
          grp[0] <= '0;
        end
        abre_pkg::S_RESC: begin
          if (rd_pend) rsum <= rsum + (ram_rdata >> 1);
          if (!idx[8]) begin
            if (idx[4:0] == 5'd0 && idx[7:5] != 3'd0)
              grp[idx[7:5]] <= rsum + (rd_pend ? (ram_rdata >> 1) : '0);
            idx <= idx + 9'd1;
            rd_pend <= 1'b1;
          end else if (rd_pend) begin
            total <= abre_pkg::TotReset + rsum + (ram_rdata >> 1);
          end
        end
        abre_pkg::S_FLUSH: if (!out_valid && fbytes != 3'd4) begin
          out_valid <= 1'b1;
          code_byte <= low[31:24];
          last_byte <= (fbytes == 3'd3);
          low <= low << 8;
          fbytes <= fbytes + 3'd1;
          if (fbytes == 3'd3) idx <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule
